@@ src/dkc_pkg.sv @@
package dkc_pkg;

  // Accent key codes, Latin-1.
  localparam logic [7:0] AccTilde     = 8'd126;
  localparam logic [7:0] AccGrave     = 8'd96;
  localparam logic [7:0] AccQuote     = 8'd34;
  localparam logic [7:0] AccDiaeresis = 8'd168;
  localparam logic [7:0] AccApos      = 8'd39;
  localparam logic [7:0] AccCaret     = 8'd94;

  // Other special codes.
  localparam logic [7:0] CharNone  = 8'd0;
  localparam logic [7:0] CharSpace = 8'd32;

  // One result as it sits in the output register.
  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } res_t;

  function automatic logic is_accent(input logic [7:0] c);
    return (c == AccTilde) || (c == AccGrave) || (c == AccQuote) ||
           (c == AccDiaeresis) || (c == AccApos) || (c == AccCaret);
  endfunction

  // Composed Latin-1 letter for an accent and a base letter; zero on a miss.
  function automatic logic [7:0] compose(input logic [7:0] accent, input logic [7:0] c);
    logic [7:0] r;
    r = CharNone;
    case (accent)
      AccTilde: begin
        case (c)
          "a":     r = 8'd227;
          "A":     r = 8'd195;
          "n":     r = 8'd241;
          "N":     r = 8'd209;
          "o":     r = 8'd245;
          "O":     r = 8'd213;
          default: r = CharNone;
        endcase
      end
      AccGrave: begin
        case (c)
          "a":     r = 8'd224;
          "A":     r = 8'd192;
          "e":     r = 8'd232;
          "E":     r = 8'd200;
          "i":     r = 8'd236;
          "I":     r = 8'd204;
          "o":     r = 8'd242;
          "O":     r = 8'd210;
          "u":     r = 8'd249;
          "U":     r = 8'd217;
          default: r = CharNone;
        endcase
      end
      AccApos: begin
        case (c)
          "a":     r = 8'd225;
          "A":     r = 8'd193;
          "e":     r = 8'd233;
          "E":     r = 8'd201;
          "i":     r = 8'd237;
          "I":     r = 8'd205;
          "o":     r = 8'd243;
          "O":     r = 8'd211;
          "u":     r = 8'd250;
          "U":     r = 8'd218;
          default: r = CharNone;
        endcase
      end
      AccQuote, AccDiaeresis: begin
        case (c)
          "a":     r = 8'd228;
          "A":     r = 8'd196;
          "e":     r = 8'd235;
          "E":     r = 8'd203;
          "i":     r = 8'd239;
          "I":     r = 8'd207;
          "o":     r = 8'd246;
          "O":     r = 8'd214;
          "u":     r = 8'd252;
          "U":     r = 8'd220;
          "y":     r = 8'd255;
          default: r = CharNone;
        endcase
      end
      AccCaret: begin
        case (c)
          "a":     r = 8'd226;
          "A":     r = 8'd194;
          "e":     r = 8'd234;
          "E":     r = 8'd202;
          "i":     r = 8'd238;
          "I":     r = 8'd206;
          "o":     r = 8'd244;
          "O":     r = 8'd212;
          "u":     r = 8'd251;
          "U":     r = 8'd219;
          default: r = CharNone;
        endcase
      end
      default: r = CharNone;
    endcase
    return r;
  endfunction

endpackage

@@ src/dead_key_composer.sv @@
// Dead-key accent composer for 8-bit Latin-1 character codes.
// Input channel: in_valid_i / in_stall_o with char_in_i; one item is one typed code.
// Output channel: out_valid_o / out_stall_i with char_out_o and last_o; an item
// causes zero, one or two results, and last_o marks the final one of them.
// An accepted item is held in the input register and is then resolved
// against the pending accent into the result register, which shows the first
// result. Items that give zero or one result flow at one item per cycle while
// the receiver does not stall. An item that gives two results holds the single
// output port until both are taken, so the output port then sets the rate.
// When the receiver stalls, the result register holds its contents and the
// input register waits unless its item gives no result; in_stall_o rises once
// the input register is full and cannot be resolved.
// Reset clears both registers' valid state and the pending accent; results
// not yet taken are dropped.
module dead_key_composer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_out_o,
  output logic       last_o
);
  import dkc_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_char_q;
  logic [7:0] pend_q, pend_d;
  res_t       res0_q, res0_d, res1_q, res1_d;
  logic [1:0] cnt_q, cnt_d;

  logic       in_acc, pop, go;
  logic [1:0] n_new;
  res_t       new0, new1;
  logic [7:0] hit;
  logic [7:0] pend_new;

  // Resolve the held item against the pending accent.
  always_comb begin
    hit      = compose(pend_q, s1_char_q);
    n_new    = 2'd0;
    new0     = '0;
    new1     = '0;
    pend_new = pend_q;
    if (is_accent(s1_char_q)) begin
      if (pend_q != CharNone) begin
        n_new    = 2'd2;
        new0     = '{char_out: pend_q, last: 1'b0};
        new1     = '{char_out: s1_char_q, last: 1'b1};
        pend_new = CharNone;
      end else begin
        pend_new = s1_char_q;
      end
    end else if (s1_char_q == CharNone) begin
      n_new = 2'd0;
    end else if (pend_q != CharNone) begin
      pend_new = CharNone;
      if (hit != CharNone) begin
        n_new = 2'd1;
        new0  = '{char_out: hit, last: 1'b1};
      end else if (s1_char_q == CharSpace) begin
        n_new = 2'd1;
        new0  = '{char_out: pend_q, last: 1'b1};
      end else begin
        n_new = 2'd2;
        new0  = '{char_out: pend_q, last: 1'b0};
        new1  = '{char_out: s1_char_q, last: 1'b1};
      end
    end else begin
      n_new = 2'd1;
      new0  = '{char_out: s1_char_q, last: 1'b1};
    end
  end

  // Handshakes: the held item resolves once the result register frees up, or at once if it gives no result.
  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign go          = s1_valid_q &&
                       ((n_new == 2'd0) || (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  assign in_stall_o  = s1_valid_q && !go;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign char_out_o  = res0_q.char_out;
  assign last_o      = res0_q.last;

  // Next state of the input register, the pending accent and the results.
  always_comb begin
    s1_valid_d = s1_valid_q;
    pend_d     = pend_q;
    res0_d     = res0_q;
    res1_d     = res1_q;
    cnt_d      = cnt_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (go) begin
      s1_valid_d = 1'b0;
    end
    if (go) begin
      pend_d = pend_new;
    end
    if (go && (n_new != 2'd0)) begin
      res0_d = new0;
      res1_d = new1;
      cnt_d  = n_new;
    end else if (pop) begin
      res0_d = res1_q;
      cnt_d  = cnt_q - 2'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= CharNone;
      cnt_q      <= 2'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      pend_q     <= pend_d;
      cnt_q      <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q <= char_in_i;
    end
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

  // The result register never holds more than two results.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("result count out of range");

  // With two results held, only the second one is the final one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (!res0_q.last && res1_q.last))
    else $error("last flag misplaced in result pair");

  // The pending byte is empty or one of the accent keys.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == CharNone) || is_accent(pend_q))
    else $error("pending byte is not an accent");

  // A stall on the input means an item is waiting in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

endmodule
